FILE: design/fault_triggered_trace_recorder_core_defines.svh
// Assertion macros used by the recorder core module.
`ifndef FAULT_TRIGGERED_TRACE_RECORDER_CORE_DEFINES_SVH
`define FAULT_TRIGGERED_TRACE_RECORDER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define FTR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define FTR_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define FTR_ASSERT(label, prop, msg)

`define FTR_ASSERT_NEVER(label, cond, msg)

`endif

`endif

FILE: design/ftr_pkg.sv
package ftr_pkg;

  localparam int unsigned CapacityDef   = 32;
  localparam int unsigned EventWidthDef = 64;
  localparam int unsigned DataW         = 64;
  localparam int unsigned ReqW          = 7;
  localparam int unsigned CountW        = 32;
  localparam int unsigned PostW         = 16;
  localparam int unsigned ApbDataW      = 32;
  localparam int unsigned CfgAddrW      = 3;

  localparam logic [PostW-1:0] PostTriggerReset = 16'd16;

  typedef logic [CfgAddrW-3:0] reg_idx_t;
  localparam reg_idx_t RegPostTrigger = '0;

  typedef enum logic [1:0] {
    OP_RECORD,
    OP_FREEZE,
    OP_CLEAR,
    OP_SNAPSHOT
  } opcode_e;

  typedef enum logic [2:0] {
    ST_RECORDED,
    ST_DROPPED,
    ST_FROZEN_NOW,
    ST_ALREADY_FROZEN,
    ST_CLEARED,
    ST_ENTRY,
    ST_EMPTY,
    ST_REFUSED
  } status_e;

endpackage

FILE: design/ftr_cfg.sv
module ftr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ftr_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ftr_pkg::ApbDataW-1:0]  pwdata,
  output logic [ftr_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output logic [ftr_pkg::PostW-1:0]     post_trigger_count_o
);
  import ftr_pkg::*;

  logic [PostW-1:0] ptc_q;
  logic             hit;
  logic             wr_en;

  assign hit   = (reg_idx_t'(paddr[CfgAddrW-1:2]) == RegPostTrigger);
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptc_q <= PostTriggerReset;
    end else if (wr_en && hit) begin
      ptc_q <= pwdata[PostW-1:0];
    end
  end

  assign prdata               = hit ? ApbDataW'(ptc_q) : '0;
  assign pready               = 1'b1;
  assign post_trigger_count_o = ptc_q;

endmodule

FILE: design/ftr_store.sv
module ftr_store #(
  parameter  int unsigned CAPACITY    = ftr_pkg::CapacityDef,
  parameter  int unsigned EVENT_WIDTH = ftr_pkg::EventWidthDef,
  localparam int unsigned AddrW       = $clog2(CAPACITY)
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic [EVENT_WIDTH-1:0] wdata_i,
  input  logic                   re_i,
  input  logic [AddrW-1:0]       raddr_i,
  output logic [EVENT_WIDTH-1:0] rdata_o
);

  logic [EVENT_WIDTH-1:0] mem_q [CAPACITY];
  logic [EVENT_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/fault_triggered_trace_recorder_core.sv
// Channel   | Handshake                  | Payload
// ----------+----------------------------+---------------------------------------------
// item in   | start, busy                | opcode_i, event_data_i, requested_count_i
// result    | result_valid_o (no stall)  | status_o, entry_data_o, last_o,
//           |                            | dropped_total_o, is_frozen_o
// config    | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// Record, freeze and clear never raise busy; after them a new item may follow every cycle.
// The first result of each item is registered and shows in the cycle after the item is accepted.
// A snapshot of n entries makes one read of the event store per cycle, one result per entry;
// busy is raised only when n exceeds one and stays high until the read of the last entry.
// Reset clears counters and flags; the event store is not cleared.
// Results cannot be held off by the receiver.
`include "fault_triggered_trace_recorder_core_defines.svh"

module fault_triggered_trace_recorder_core #(
  parameter int unsigned CAPACITY    = ftr_pkg::CapacityDef,
  parameter int unsigned EVENT_WIDTH = ftr_pkg::EventWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ftr_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ftr_pkg::ApbDataW-1:0]  pwdata,
  output logic [ftr_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode_i,
  input  logic [ftr_pkg::DataW-1:0]     event_data_i,
  input  logic [ftr_pkg::ReqW-1:0]      requested_count_i,
  output logic                          result_valid_o,
  output logic [2:0]                    status_o,
  output logic [ftr_pkg::DataW-1:0]     entry_data_o,
  output logic                          last_o,
  output logic [ftr_pkg::CountW-1:0]    dropped_total_o,
  output logic                          is_frozen_o
);
  import ftr_pkg::*;

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_SNAP
  } state_e;

  state_e            state_q, state_d;
  logic [CountW-1:0] wt_q, wt_d;
  logic              frozen_q, frozen_d;
  logic [PostW-1:0]  post_q, post_d;
  logic [CountW-1:0] drop_q, drop_d;
  logic [CntW-1:0]   left_q, left_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic              res_valid_q, res_valid_d;
  status_e           res_status_q, res_status_d;
  logic              res_last_q, res_last_d;

  logic [PostW-1:0]       ptc;
  logic                   accept;
  logic [CountW-1:0]      stored;
  logic [CountW-1:0]      req_ext;
  logic [CountW-1:0]      take;
  logic [CntW-1:0]        n;
  logic [AddrW-1:0]       first_idx;

  logic                   mem_we;
  logic [AddrW-1:0]       mem_waddr;
  logic [EVENT_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [AddrW-1:0]       mem_raddr;
  logic [EVENT_WIDTH-1:0] mem_rdata;

  ftr_cfg u_cfg (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .post_trigger_count_o (ptc)
  );

  ftr_store #(
    .CAPACITY    (CAPACITY),
    .EVENT_WIDTH (EVENT_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign busy   = (state_q == S_SNAP);
  assign accept = start && !busy;

  assign stored    = (wt_q >= CountW'(CAPACITY)) ? CountW'(CAPACITY) : wt_q;
  assign req_ext   = CountW'(requested_count_i);
  assign take      = (req_ext < stored) ? req_ext : stored;
  assign n         = take[CntW-1:0];
  assign first_idx = wt_q[AddrW-1:0] - n[AddrW-1:0];

  always_comb begin
    state_d      = state_q;
    wt_d         = wt_q;
    frozen_d     = frozen_q;
    post_d       = post_q;
    drop_d       = drop_q;
    left_d       = left_q;
    rd_ptr_d     = rd_ptr_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_last_d   = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = wt_q[AddrW-1:0];
    mem_wdata    = event_data_i[EVENT_WIDTH-1:0];
    mem_re       = 1'b0;
    mem_raddr    = rd_ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          res_last_d  = 1'b1;
          unique case (opcode_e'(opcode_i))
            OP_RECORD: begin
              if (frozen_q && (post_q == '0)) begin
                drop_d       = drop_q + CountW'(1);
                res_status_d = ST_DROPPED;
              end else begin
                if (frozen_q) begin
                  post_d = post_q - PostW'(1);
                end
                mem_we       = 1'b1;
                wt_d         = wt_q + CountW'(1);
                res_status_d = ST_RECORDED;
              end
            end
            OP_FREEZE: begin
              if (frozen_q) begin
                res_status_d = ST_ALREADY_FROZEN;
              end else begin
                frozen_d     = 1'b1;
                post_d       = ptc;
                res_status_d = ST_FROZEN_NOW;
              end
            end
            OP_CLEAR: begin
              frozen_d     = 1'b0;
              post_d       = '0;
              drop_d       = '0;
              wt_d         = '0;
              res_status_d = ST_CLEARED;
            end
            OP_SNAPSHOT: begin
              if (requested_count_i == '0) begin
                res_status_d = ST_REFUSED;
              end else if (wt_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                res_status_d = ST_ENTRY;
                mem_re       = 1'b1;
                mem_raddr    = first_idx;
                res_last_d   = (n == CntW'(1));
                rd_ptr_d     = first_idx + AddrW'(1);
                left_d       = n - CntW'(1);
                if (n != CntW'(1)) begin
                  state_d = S_SNAP;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_SNAP: begin
        mem_re       = 1'b1;
        res_valid_d  = 1'b1;
        res_status_d = ST_ENTRY;
        res_last_d   = (left_q == CntW'(1));
        rd_ptr_d     = rd_ptr_q + AddrW'(1);
        left_d       = left_q - CntW'(1);
        if (left_q == CntW'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      wt_q         <= '0;
      frozen_q     <= 1'b0;
      post_q       <= '0;
      drop_q       <= '0;
      left_q       <= '0;
      rd_ptr_q     <= '0;
      res_valid_q  <= 1'b0;
      res_status_q <= ST_RECORDED;
      res_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      wt_q         <= wt_d;
      frozen_q     <= frozen_d;
      post_q       <= post_d;
      drop_q       <= drop_d;
      left_q       <= left_d;
      rd_ptr_q     <= rd_ptr_d;
      res_valid_q  <= res_valid_d;
      res_status_q <= res_status_d;
      res_last_q   <= res_last_d;
    end
  end

  assign result_valid_o  = res_valid_q;
  assign status_o        = res_status_q;
  assign last_o          = res_last_q;
  assign entry_data_o    = (res_valid_q && (res_status_q == ST_ENTRY)) ? DataW'(mem_rdata) : '0;
  assign dropped_total_o = drop_q;
  assign is_frozen_o     = frozen_q;

  `FTR_ASSERT(a_snap_streams, busy |=> result_valid_o && (status_o == ST_ENTRY),
              "snapshot word missing while busy")
  `FTR_ASSERT(a_last_frees, (result_valid_o && last_o && (status_o == ST_ENTRY)) |-> !busy,
              "busy after last snapshot word")
  `FTR_ASSERT(a_unfreeze_by_clear,
              $fell(is_frozen_o) |-> $past(accept && (opcode_i == OP_CLEAR)),
              "frozen flag dropped without clear")
  `FTR_ASSERT(a_drop_step, (dropped_total_o != $past(dropped_total_o)) |->
              (dropped_total_o == $past(dropped_total_o) + CountW'(1)) ||
              (dropped_total_o == '0),
              "drop counter jumped")
  `FTR_ASSERT_NEVER(a_last_alone, last_o && !result_valid_o, "last without result")

endmodule
